// File: sv/jab_pkg.sv
// Package for the joint acceleration bound pipeline.
// Holds field widths, register indexes, reset values and stage enable types.
// No dependencies; every other file of the block imports it.
package jab_pkg;

  // Default number of fractional bits of the fixed point format.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int unsigned POS_W  = 32;
  localparam int unsigned LIM_W  = 31;
  localparam int unsigned HOR_W  = 32;
  localparam int unsigned INV_W  = 48;

  // Configuration port.
  localparam int unsigned CFG_W     = 48;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_HOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_HOR_SQ = 2'd2;

  localparam logic [HOR_W-1:0] HORIZON_RST    = 32'd65;
  localparam logic [INV_W-1:0] INV_HOR_RST    = 48'd65536000;
  localparam logic [INV_W-1:0] INV_HOR_SQ_RST = 48'd65536000000;

  // Split point of the wide multiplier operands.
  localparam int unsigned SPLIT_W = 24;

  // Saturation limits of the 32-bit results.
  localparam logic [POS_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] S32_MIN = 32'h8000_0000;

  // Load enables of the three multiplier stages.
  typedef struct packed {
    logic prod;
    logic sum;
    logic fin;
  } mul_en_t;

  // Load enables of the two bound selection stages.
  typedef struct packed {
    logic cand;
    logic fin;
  } bnd_en_t;

endpackage

// File: sv/jab_if.sv
// Valid/ready channel interfaces for the joint acceleration bound pipeline.
// Depends on jab_pkg for the field widths.
interface jab_in_if;
  import jab_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  logic signed [POS_W-1:0] velocity;
  logic signed [POS_W-1:0] position_max;
  logic signed [POS_W-1:0] position_min;
  logic        [LIM_W-1:0] speed_limit;
  logic        [LIM_W-1:0] accel_limit;

  modport source (
    output valid, position, velocity, position_max, position_min, speed_limit,
           accel_limit,
    input  ready
  );
  modport sink (
    input  valid, position, velocity, position_max, position_min, speed_limit,
           accel_limit,
    output ready
  );
endinterface

interface jab_out_if;
  import jab_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] accel_upper;
  logic signed [POS_W-1:0] accel_lower;

  modport source (output valid, accel_upper, accel_lower, input ready);
  modport sink (input valid, accel_upper, accel_lower, output ready);
endinterface

// File: sv/jab_mul_sat.sv
// Three-stage signed-by-unsigned fixed point multiplier with floor and saturation.
// Splits both operands into partial products of at most about 26 by 24 bits.
// Depends on jab_pkg.
module jab_mul_sat #(
  parameter int unsigned FRAC_BITS = jab_pkg::FRAC_BITS_DEF,
  parameter int unsigned OPA_W     = 50
) (
  input  logic                             clk_i,
  input  jab_pkg::mul_en_t                 en_i,
  input  logic signed [OPA_W-1:0]          a_i,
  input  logic        [jab_pkg::INV_W-1:0] b_i,
  output logic signed [jab_pkg::POS_W-1:0] res_o
);
  import jab_pkg::*;

  localparam int unsigned HI_W  = OPA_W - SPLIT_W;
  localparam int unsigned BH_W  = INV_W - SPLIT_W;
  localparam int unsigned LL_W  = 2 * SPLIT_W;
  localparam int unsigned LH_W  = SPLIT_W + BH_W;
  localparam int unsigned HL_W  = HI_W + SPLIT_W + 1;
  localparam int unsigned HH_W  = HI_W + BH_W + 1;
  localparam int unsigned S1_W  = LH_W + SPLIT_W + 1;
  localparam int unsigned S2_W  = HH_W + SPLIT_W + 1;
  localparam int unsigned P_W   = S2_W + SPLIT_W + 1;
  localparam int unsigned SH_W  = P_W - FRAC_BITS;

  logic        [SPLIT_W-1:0] a_lo;
  logic signed [HI_W-1:0]    a_hi;
  logic        [SPLIT_W-1:0] b_lo;
  logic        [BH_W-1:0]    b_hi;

  logic        [LL_W-1:0] ll_d, ll_q;
  logic        [LH_W-1:0] lh_d, lh_q;
  logic signed [HL_W-1:0] hl_d, hl_q;
  logic signed [HH_W-1:0] hh_d, hh_q;
  logic        [S1_W-1:0] s1_d, s1_q;
  logic        [S2_W-1:0] s2_d, s2_q;
  logic        [P_W-1:0]  prod;
  logic        [SH_W-1:0] shifted;
  logic                   fits;
  logic        [POS_W-1:0] res_d, res_q;

  // Partial products of the operand halves.
  always_comb begin
    a_lo = a_i[SPLIT_W-1:0];
    a_hi = a_i[OPA_W-1:SPLIT_W];
    b_lo = b_i[SPLIT_W-1:0];
    b_hi = b_i[INV_W-1:SPLIT_W];
    ll_d = a_lo * b_lo;
    lh_d = a_lo * b_hi;
    hl_d = a_hi * $signed({1'b0, b_lo});
    hh_d = a_hi * $signed({1'b0, b_hi});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
    end
  end

  // Fold the low and the high operand half each into one sum.
  always_comb begin
    s1_d = {{(S1_W-LL_W){1'b0}}, ll_q} + {1'b0, lh_q, {SPLIT_W{1'b0}}};
    s2_d = {{(S2_W-HL_W){hl_q[HL_W-1]}}, hl_q} + {hh_q[HH_W-1], hh_q, {SPLIT_W{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  // Final sum, floor by dropping the fraction, then saturate to 32 bits.
  always_comb begin
    prod    = {s2_q[S2_W-1], s2_q, {SPLIT_W{1'b0}}} + {{(P_W-S1_W){1'b0}}, s1_q};
    shifted = prod[P_W-1:FRAC_BITS];
    fits    = (&shifted[SH_W-1:POS_W-1]) || !(|shifted[SH_W-1:POS_W-1]);
    if (fits) begin
      res_d = shifted[POS_W-1:0];
    end else if (shifted[SH_W-1]) begin
      res_d = S32_MIN;
    end else begin
      res_d = S32_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.fin) begin
      res_q <= res_d;
    end
  end

  assign res_o = $signed(res_q);

endmodule

// File: sv/jab_bound.sv
// Two-stage bound selection: min/max against the acceleration limit, then
// swap of crossed bounds and the final clamp. Depends on jab_pkg.
module jab_bound (
  input  logic                             clk_i,
  input  jab_pkg::bnd_en_t                 en_i,
  input  logic signed [jab_pkg::POS_W-1:0] pmax_i,
  input  logic signed [jab_pkg::POS_W-1:0] pmin_i,
  input  logic signed [jab_pkg::POS_W-1:0] vmax_i,
  input  logic signed [jab_pkg::POS_W-1:0] vmin_i,
  input  logic        [jab_pkg::LIM_W-1:0] alim_i,
  output logic signed [jab_pkg::POS_W-1:0] upper_o,
  output logic signed [jab_pkg::POS_W-1:0] lower_o
);
  import jab_pkg::*;

  localparam int unsigned EXT_W = POS_W + 1;

  logic signed [EXT_W-1:0] alim_s, nalim_s;
  logic signed [EXT_W-1:0] pmax_s, pmin_s, vmax_s, vmin_s;
  logic signed [EXT_W-1:0] up_min, lo_max;
  logic signed [EXT_W-1:0] up_d, up_q, lo_d, lo_q;
  logic        [LIM_W-1:0] alim_q;
  logic signed [EXT_W-1:0] alim2_s, nalim2_s;
  logic signed [EXT_W-1:0] up_sw, lo_sw, up_cl, lo_cl;
  logic        [POS_W-1:0] upper_q, lower_q;

  // Candidate bounds: upper is the smallest, lower the largest limit.
  always_comb begin
    alim_s  = $signed({2'b00, alim_i});
    nalim_s = -alim_s;
    pmax_s  = $signed({pmax_i[POS_W-1], pmax_i});
    pmin_s  = $signed({pmin_i[POS_W-1], pmin_i});
    vmax_s  = $signed({vmax_i[POS_W-1], vmax_i});
    vmin_s  = $signed({vmin_i[POS_W-1], vmin_i});
    up_min  = (pmax_s < vmax_s) ? pmax_s : vmax_s;
    lo_max  = (pmin_s > vmin_s) ? pmin_s : vmin_s;
    up_d    = (up_min < alim_s) ? up_min : alim_s;
    lo_d    = (lo_max > nalim_s) ? lo_max : nalim_s;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.cand) begin
      up_q   <= up_d;
      lo_q   <= lo_d;
      alim_q <= alim_i;
    end
  end

  // Swap crossed bounds, then clamp both into the acceleration limit.
  always_comb begin
    alim2_s  = $signed({2'b00, alim_q});
    nalim2_s = -alim2_s;
    if (up_q < lo_q) begin
      up_sw = lo_q;
      lo_sw = up_q;
    end else begin
      up_sw = up_q;
      lo_sw = lo_q;
    end
    up_cl = (up_sw > alim2_s) ? alim2_s : up_sw;
    lo_cl = (lo_sw < nalim2_s) ? nalim2_s : lo_sw;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.fin) begin
      upper_q <= up_cl[POS_W-1:0];
      lower_q <= lo_cl[POS_W-1:0];
    end
  end

  assign upper_o = $signed(upper_q);
  assign lower_o = $signed(lower_q);

endmodule

// File: sv/joint_accel_bound_calc.sv
// Joint acceleration bounds from a look-ahead horizon, seven-stage pipeline.
// Takes one request per cycle while results are taken; back-pressure from out_o.ready can stall it.
// Each stage holds only while it is full and the stage after it cannot load.
// Reset clears all stage valid bits and loads the horizon registers with their defaults.
// Depends on jab_pkg, jab_if, jab_mul_sat and jab_bound.
module joint_accel_bound_calc #(
  parameter int unsigned FRAC_BITS = jab_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [jab_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [jab_pkg::CFG_W-1:0]            cfg_wdata_i,
  jab_in_if.sink                               in_i,
  jab_out_if.source                            out_o
);
  import jab_pkg::*;

  localparam int unsigned NUM_ST = 7;
  localparam int unsigned PROD_W = 2 * POS_W + 2;
  localparam int unsigned DIFF_W = PROD_W - FRAC_BITS;
  localparam int unsigned EXT_W  = POS_W + 1;
  localparam int unsigned TRV_W  = PROD_W - FRAC_BITS;

  // Configuration registers.
  logic [HOR_W-1:0] horizon_q;
  logic [INV_W-1:0] inv_hor_q;
  logic [INV_W-1:0] inv_hor_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q    <= HORIZON_RST;
      inv_hor_q    <= INV_HOR_RST;
      inv_hor_sq_q <= INV_HOR_SQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HORIZON:    horizon_q    <= cfg_wdata_i[HOR_W-1:0];
        CFG_INV_HOR:    inv_hor_q    <= cfg_wdata_i[INV_W-1:0];
        CFG_INV_HOR_SQ: inv_hor_sq_q <= cfg_wdata_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the backward load enables.
  logic [NUM_ST:1] v_q;
  logic [NUM_ST:1] en;

  always_comb begin
    en[NUM_ST] = !v_q[NUM_ST] || out_o.ready;
    for (int k = NUM_ST - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_i.valid;
      end
      for (int k = 2; k <= NUM_ST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_i.ready = en[1];

  // Stage 1: travel product and the limit differences.
  logic signed [PROD_W-1:0] trv_prod_q;
  logic signed [EXT_W-1:0]  dmax_q, dmin_q, vmax_op_q, vmin_op_q;
  logic        [LIM_W-1:0]  alim_q [1:5];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      trv_prod_q <= in_i.velocity * $signed({1'b0, horizon_q});
      dmax_q     <= $signed({in_i.position_max[POS_W-1], in_i.position_max}
                            - {in_i.position[POS_W-1], in_i.position});
      dmin_q     <= $signed({in_i.position_min[POS_W-1], in_i.position_min}
                            - {in_i.position[POS_W-1], in_i.position});
      vmax_op_q  <= $signed({2'b00, in_i.speed_limit}
                            - {in_i.velocity[POS_W-1], in_i.velocity});
      vmin_op_q  <= $signed({EXT_W{1'b0}} - {2'b00, in_i.speed_limit}
                            - {in_i.velocity[POS_W-1], in_i.velocity});
    end
  end

  // Stage 2: floor the travel and form the four multiplier operands.
  logic [TRV_W-1:0]         travel;
  logic signed [DIFF_W-1:0] pmax_op_q, pmin_op_q, vmax_w_q, vmin_w_q;

  assign travel = trv_prod_q[PROD_W-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pmax_op_q <= $signed({{(DIFF_W-EXT_W){dmax_q[EXT_W-1]}}, dmax_q} - travel);
      pmin_op_q <= $signed({{(DIFF_W-EXT_W){dmin_q[EXT_W-1]}}, dmin_q} - travel);
      vmax_w_q  <= $signed({{(DIFF_W-EXT_W){vmax_op_q[EXT_W-1]}}, vmax_op_q});
      vmin_w_q  <= $signed({{(DIFF_W-EXT_W){vmin_op_q[EXT_W-1]}}, vmin_op_q});
    end
  end

  // Stages 3 to 5: four scaled bounds.
  mul_en_t mul_en;
  logic signed [POS_W-1:0] pmax, pmin, vmax, vmin;

  assign mul_en = '{prod: en[3], sum: en[4], fin: en[5]};

  jab_mul_sat #(.FRAC_BITS(FRAC_BITS), .OPA_W(DIFF_W)) u_mul_pmax (
    .clk_i(clk_i), .en_i(mul_en), .a_i(pmax_op_q), .b_i(inv_hor_sq_q), .res_o(pmax)
  );
  jab_mul_sat #(.FRAC_BITS(FRAC_BITS), .OPA_W(DIFF_W)) u_mul_pmin (
    .clk_i(clk_i), .en_i(mul_en), .a_i(pmin_op_q), .b_i(inv_hor_sq_q), .res_o(pmin)
  );
  jab_mul_sat #(.FRAC_BITS(FRAC_BITS), .OPA_W(DIFF_W)) u_mul_vmax (
    .clk_i(clk_i), .en_i(mul_en), .a_i(vmax_w_q), .b_i(inv_hor_q), .res_o(vmax)
  );
  jab_mul_sat #(.FRAC_BITS(FRAC_BITS), .OPA_W(DIFF_W)) u_mul_vmin (
    .clk_i(clk_i), .en_i(mul_en), .a_i(vmin_w_q), .b_i(inv_hor_q), .res_o(vmin)
  );

  // Acceleration limit travels alongside stages 1 to 5.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      alim_q[1] <= in_i.accel_limit;
    end
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) begin
        alim_q[k] <= alim_q[k-1];
      end
    end
  end

  // Stages 6 and 7: selection, swap and clamp into the output register.
  bnd_en_t bnd_en;

  assign bnd_en = '{cand: en[6], fin: en[7]};

  jab_bound u_bound (
    .clk_i   (clk_i),
    .en_i    (bnd_en),
    .pmax_i  (pmax),
    .pmin_i  (pmin),
    .vmax_i  (vmax),
    .vmin_i  (vmin),
    .alim_i  (alim_q[5]),
    .upper_o (out_o.accel_upper),
    .lower_o (out_o.accel_lower)
  );

  assign out_o.valid = v_q[NUM_ST];

endmodule

// File: sv/jab_checker.sv
// Port-level checks for joint_accel_bound_calc, attached by a bind statement.
// Depends on jab_pkg and on the top level's ports.
module jab_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [jab_pkg::POS_W-1:0] out_upper_i,
  input logic signed [jab_pkg::POS_W-1:0] out_lower_i
);
  import jab_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  // With the output side empty the pipeline always takes a request.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request refused while the output stage is empty");

  // An accepted request reaches the output while the sink stays ready behind it.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after pipeline latency");

  // Swap and clamp leave the bounds ordered.
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_upper_i >= out_lower_i)
    else $error("upper bound below lower bound");

endmodule

bind joint_accel_bound_calc jab_checker u_jab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_upper_i (out_o.accel_upper),
  .out_lower_i (out_o.accel_lower)
);

// File: dv/joint_accel_bound_calc_test.sv
// Self-checking testbench for joint_accel_bound_calc: random and corner-case joint requests
// are checked against an in-bench bound predictor across several horizon register settings.
// Depends on jab_pkg, jab_if and the joint_accel_bound_calc RTL.
`timescale 1ns / 1ps

module joint_accel_bound_calc_test;
  import jab_pkg::*;

  localparam int          FRAC       = FRAC_BITS_DEF;
  localparam int          LATENCY    = 7;
  localparam int          CYCLE_MAX  = 500000;
  localparam int          REPORT_MAX = 100;
  localparam int          SET_CNT    = 8;
  // Index past the last register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [POS_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] ONE   = 32'sh0001_0000;
  localparam logic        [LIM_W-1:0] L_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] velocity;
    logic signed [POS_W-1:0] position_max;
    logic signed [POS_W-1:0] position_min;
    logic        [LIM_W-1:0] speed_limit;
    logic        [LIM_W-1:0] accel_limit;
  } joint_req_t;

  typedef struct packed {
    logic signed [POS_W-1:0] upper;
    logic signed [POS_W-1:0] lower;
  } bound_pair_t;

  typedef enum {
    SET_RESET, SET_TYPICAL, SET_ZERO, SET_ALL_MAX, SET_SCRAMBLED, SET_ALL_ONE, SET_SHORTEST
  } horizon_set_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]  cfg_wdata_i;

  jab_in_if  in_if ();
  jab_out_if out_if ();

  joint_accel_bound_calc u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Bench copy of the horizon registers.
  logic [HOR_W-1:0] horizon_reg  = HORIZON_RST;
  logic [INV_W-1:0] recip_reg    = INV_HOR_RST;
  logic [INV_W-1:0] recip_sq_reg = INV_HOR_SQ_RST;

  joint_req_t  joint_req_q[$];
  bound_pair_t bound_pairs_q[$];
  joint_req_t  cur_req;
  int          in_flight   = 0;
  int          gap_left    = 0;
  int          stall_left  = 0;
  int          sent_cnt    = 0;
  int          checked_cnt = 0;
  int          err_cnt     = 0;
  int          cycle_cnt   = 0;
  bit          no_idle     = 1'b0;

  // Saturate a wide value to the signed 32-bit range.
  function automatic logic signed [127:0] clamp_s32(logic signed [127:0] x);
    if (x > 128'sd2147483647) return 128'sd2147483647;
    if (x < -128'sd2147483648) return -128'sd2147483648;
    return x;
  endfunction

  // Acceleration bounds for one request under the current horizon registers.
  function automatic bound_pair_t accel_bounds_of(joint_req_t r);
    logic signed [127:0] q, qd, qmax, qmin, vlim, alim, hor, rcp, rcp_sq;
    logic signed [127:0] travel, pmax, pmin, vmax, vmin, up, lo, swap;
    bound_pair_t res;
    q      = 128'(r.position);
    qd     = 128'(r.velocity);
    qmax   = 128'(r.position_max);
    qmin   = 128'(r.position_min);
    vlim   = $signed({97'd0, r.speed_limit});
    alim   = $signed({97'd0, r.accel_limit});
    hor    = $signed({96'd0, horizon_reg});
    rcp    = $signed({80'd0, recip_reg});
    rcp_sq = $signed({80'd0, recip_sq_reg});
    // Arithmetic shifts of exact products give floor rounding.
    travel = (qd * hor) >>> FRAC;
    pmax   = clamp_s32(((qmax - q - travel) * rcp_sq) >>> FRAC);
    pmin   = clamp_s32(((qmin - q - travel) * rcp_sq) >>> FRAC);
    vmax   = clamp_s32(((vlim - qd) * rcp) >>> FRAC);
    vmin   = clamp_s32(((-vlim - qd) * rcp) >>> FRAC);
    up = (pmax < vmax) ? pmax : vmax;
    if (alim < up) up = alim;
    lo = (pmin > vmin) ? pmin : vmin;
    if (lo < -alim) lo = -alim;
    // Crossed bounds are swapped, then both are held within the acceleration limit.
    if (up < lo) begin
      swap = up;
      up   = lo;
      lo   = swap;
    end
    if (lo < -alim) lo = -alim;
    if (up > alim) up = alim;
    res.upper = up[POS_W-1:0];
    res.lower = lo[POS_W-1:0];
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Mostly plausible joint states at random scales, the rest raw bits with corners mixed in.
  function automatic joint_req_t random_request();
    joint_req_t r;
    longint     span, lo_l, hi_l, vspan;
    if ($urandom_range(0, 9) < 7) begin
      span  = longint'(1) << $urandom_range(6, 30);
      lo_l  = -longint'($urandom_range(0, span));
      hi_l  = longint'($urandom_range(0, span));
      r.position_min = 32'(lo_l);
      r.position_max = 32'(hi_l);
      case ($urandom_range(0, 15))
        0:       r.position = 32'(lo_l - longint'($urandom_range(0, span)));
        1:       r.position = 32'(hi_l + longint'($urandom_range(0, span)));
        default: r.position = 32'(lo_l + longint'($urandom_range(0, hi_l - lo_l)));
      endcase
      vspan = longint'(1) << $urandom_range(4, 30);
      r.velocity    = 32'(longint'($urandom_range(0, 2 * vspan)) - vspan);
      r.speed_limit = 31'($urandom_range(0, vspan));
      r.accel_limit = 31'($urandom_range(0, longint'(1) << $urandom_range(4, 30)));
    end else begin
      r.position     = $urandom;
      r.velocity     = $urandom;
      r.position_max = $urandom;
      r.position_min = $urandom;
      r.speed_limit  = 31'($urandom);
      r.accel_limit  = 31'($urandom);
      if ($urandom_range(0, 3) == 0) r.position = corner_value();
      if ($urandom_range(0, 3) == 0) r.velocity = corner_value();
      if ($urandom_range(0, 3) == 0) r.position_max = corner_value();
      if ($urandom_range(0, 3) == 0) r.position_min = corner_value();
      if ($urandom_range(0, 3) == 0) r.speed_limit = 31'(corner_value());
      if ($urandom_range(0, 3) == 0) r.accel_limit = 31'(corner_value());
    end
    return r;
  endfunction

  // One register write; the bench copy follows the same decode.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_HORIZON:    horizon_reg  = data[HOR_W-1:0];
      CFG_INV_HOR:    recip_reg    = data[INV_W-1:0];
      CFG_INV_HOR_SQ: recip_sq_reg = data[INV_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_horizon_set(horizon_set_e s);
    logic [HOR_W-1:0] t;
    logic [INV_W-1:0] r, r2;
    longint unsigned  tt;
    write_reg(CFG_SPARE, CFG_W'({$urandom, $urandom}));
    t  = horizon_reg;
    r  = recip_reg;
    r2 = recip_sq_reg;
    case (s)
      SET_TYPICAL: begin
        t  = $urandom_range(65, 131072);
        tt = 64'(t);
        r  = 48'((64'd1 << 32) / tt);
        r2 = 48'((64'd1 << 48) / (tt * tt));
      end
      SET_ZERO: begin
        t  = '0;
        r  = '0;
        r2 = '0;
      end
      SET_ALL_MAX: begin
        t  = '1;
        r  = '1;
        r2 = '1;
      end
      SET_SCRAMBLED: begin
        t  = $urandom;
        r  = 48'({$urandom, $urandom});
        r2 = 48'({$urandom, $urandom});
      end
      SET_ALL_ONE: begin
        t  = 1;
        r  = 1;
        r2 = 1;
      end
      SET_SHORTEST: begin
        t  = 1;
        r  = 48'h1_0000_0000;
        r2 = '1;
      end
      default: ;
    endcase
    if (s != SET_RESET) begin
      write_reg(CFG_HORIZON, CFG_W'(t));
      write_reg(CFG_INV_HOR, r);
      write_reg(CFG_INV_HOR_SQ, r2);
    end
  endtask

  // Clock, reset and known input levels from time zero.
  initial begin
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_HORIZON;
    cfg_wdata_i          = '0;
    in_if.valid          = 1'b0;
    in_if.position       = '0;
    in_if.velocity       = '0;
    in_if.position_max   = '0;
    in_if.position_min   = '0;
    in_if.speed_limit    = '0;
    in_if.accel_limit    = '0;
    out_if.ready         = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Request driver: takes pending requests and predicts each one as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        bound_pairs_q.push_back(accel_bounds_of(cur_req));
        in_flight--;
        sent_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (joint_req_q.size() != 0) begin
          cur_req = joint_req_q.pop_front();
          in_flight++;
          in_if.position     <= cur_req.position;
          in_if.velocity     <= cur_req.velocity;
          in_if.position_max <= cur_req.position_max;
          in_if.position_min <= cur_req.position_min;
          in_if.speed_limit  <= cur_req.speed_limit;
          in_if.accel_limit  <= cur_req.accel_limit;
          in_if.valid        <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin : result_monitor
    bound_pair_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (bound_pairs_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $error("result with no request pending: upper %0d lower %0d",
                   out_if.accel_upper, out_if.accel_lower);
        end else begin
          want = bound_pairs_q.pop_front();
          checked_cnt++;
          if (out_if.accel_upper !== want.upper) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
              $error("accel_upper: expected %0d, got %0d", want.upper, out_if.accel_upper);
          end
          if (out_if.accel_lower !== want.lower) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX)
              $error("accel_lower: expected %0d, got %0d", want.lower, out_if.accel_lower);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_MAX) begin
      $display("[joint_accel_bound_calc] ERROR");
      $finish;
    end
  end

  // Stimulus sequence: directed corners at reset settings, then random requests per setting.
  initial begin
    horizon_set_e sets[SET_CNT];
    int           per_set;
    sets = '{SET_RESET, SET_TYPICAL, SET_ZERO, SET_ALL_MAX, SET_SCRAMBLED, SET_ALL_ONE,
             SET_SHORTEST, SET_TYPICAL};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int s = 0; s < SET_CNT; s++) begin
      no_idle = (s % 3 == 2);
      apply_horizon_set(sets[s]);
      per_set = 175;
      if (s == 0) begin
        per_set = 150;
        joint_req_q.push_back('{0, 0, 0, 0, 0, 0});
        joint_req_q.push_back('{S_MAX, S_MAX, S_MAX, S_MAX, L_MAX, L_MAX});
        joint_req_q.push_back('{S_MIN, S_MIN, S_MIN, S_MIN, 0, 0});
        joint_req_q.push_back('{S_MIN, S_MAX, S_MAX, S_MIN, L_MAX, L_MAX});
        joint_req_q.push_back('{S_MAX, S_MIN, S_MAX, S_MIN, L_MAX, L_MAX});
        // Ordinary joint well inside its range.
        joint_req_q.push_back('{ONE / 2, ONE / 10, ONE, -ONE, 31'(2 * ONE), 31'(10 * ONE)});
        // Zero acceleration limit forces both bounds to zero.
        joint_req_q.push_back('{ONE / 2, ONE / 10, ONE, -ONE, 31'(2 * ONE), 0});
        joint_req_q.push_back('{$urandom, $urandom, $urandom, $urandom, 31'($urandom), 0});
        // Zero speed limit.
        joint_req_q.push_back('{ONE / 4, -ONE / 8, ONE, -ONE, 0, 31'(10 * ONE)});
        // Joint far outside its limits, so the bounds cross and get swapped.
        joint_req_q.push_back('{10 * ONE, 0, ONE, -ONE, 31'(2 * ONE), 31'(5 * ONE)});
        joint_req_q.push_back('{-10 * ONE, 0, ONE, -ONE, 31'(2 * ONE), 31'(5 * ONE)});
        // Fast motion toward either limit.
        joint_req_q.push_back('{0, S_MAX, ONE, -ONE, L_MAX, L_MAX});
        joint_req_q.push_back('{0, S_MIN, ONE, -ONE, L_MAX, L_MAX});
        // Inverted position limits.
        joint_req_q.push_back('{0, 0, -ONE, ONE, 31'(ONE), 31'(ONE)});
        // Sitting exactly on a limit.
        joint_req_q.push_back('{ONE, 0, ONE, -ONE, 31'(ONE), 31'(3 * ONE)});
        joint_req_q.push_back('{-ONE, 0, ONE, -ONE, 31'(ONE), 31'(3 * ONE)});
        // Single LSB values exercise floor rounding of negative products.
        joint_req_q.push_back('{-1, -1, -1, -1, 1, 1});
        joint_req_q.push_back('{1, 1, 1, 1, 1, 1});
        joint_req_q.push_back('{0, 0, ONE, -ONE, L_MAX, 1});
        joint_req_q.push_back('{0, -1, ONE, -ONE, 0, L_MAX});
      end
      for (int i = 0; i < per_set; i++) joint_req_q.push_back(random_request());
      // Registers change only once every request has produced its result.
      while (joint_req_q.size() != 0 || in_flight != 0 || bound_pairs_q.size() != 0)
        @(posedge clk_i);
    end
    repeat (4 * LATENCY) @(posedge clk_i);
    if (bound_pairs_q.size() != 0) begin
      err_cnt++;
      $error("%0d bound pairs never arrived", bound_pairs_q.size());
    end
    $display("Drove %0d joint requests over %0d horizon settings (reset, typical, zero,",
             sent_cnt, SET_CNT);
    $display("full-scale, unit and mismatched); %0d bound pairs checked, %0d errors.",
             checked_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("[joint_accel_bound_calc] OK");
    end else begin
      $display("[joint_accel_bound_calc] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/jab_pkg.sv
sv/jab_if.sv
sv/jab_mul_sat.sv
sv/jab_bound.sv
sv/joint_accel_bound_calc.sv
sv/jab_checker.sv
dv/joint_accel_bound_calc_test.sv
